// ===== rtl/core/cau_pkg.sv =====
// shared opcodes and item classes for the complex arithmetic unit
package cau_pkg;

	localparam int CMD_BITS = 4;
	localparam int CLS_BITS = 4;

	localparam logic [CMD_BITS-1:0] CMD_ADD  = 4'd0;
	localparam logic [CMD_BITS-1:0] CMD_SUB  = 4'd1;
	localparam logic [CMD_BITS-1:0] CMD_MUL  = 4'd2;
	localparam logic [CMD_BITS-1:0] CMD_DIV  = 4'd3;
	localparam logic [CMD_BITS-1:0] CMD_NEG  = 4'd4;
	localparam logic [CMD_BITS-1:0] CMD_ADDR = 4'd5;
	localparam logic [CMD_BITS-1:0] CMD_SUBR = 4'd6;
	localparam logic [CMD_BITS-1:0] CMD_MULR = 4'd7;
	localparam logic [CMD_BITS-1:0] CMD_DIVR = 4'd8;

	typedef enum logic [CLS_BITS-1:0] {
		CLS_ADD,
		CLS_SUB,
		CLS_MUL,
		CLS_DIV,
		CLS_NEG,
		CLS_ADDR,
		CLS_SUBR,
		CLS_MULR,
		CLS_DIVR,
		CLS_ZDIV,
		CLS_NONE
	} cls_t;

endpackage

// ===== rtl/core/complex_arith_unit_top.sv =====
// top level of the complex arithmetic unit
// throughput: one item per cycle while results are taken every cycle
// the back end holds a pipelined restoring divider, one quotient bit per stage
// reset: arst_n clears all valid flags at once; the queue comes up empty
module complex_arith_unit_top #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic [cau_pkg::CMD_BITS-1:0] cmd,
	input  logic signed [WORD_BITS-1:0]  a_re,
	input  logic signed [WORD_BITS-1:0]  a_im,
	input  logic signed [WORD_BITS-1:0]  b_re,
	input  logic signed [WORD_BITS-1:0]  b_im,
	output logic                         empty,
	input  logic                         pop,
	output logic signed [WORD_BITS-1:0]  res_re,
	output logic signed [WORD_BITS-1:0]  res_im,
	output logic                         zero_divisor,
	output logic                         overflowed
);

	// one item: class code plus the four operand words
	localparam int ITEM_BITS = cau_pkg::CLS_BITS + 4 * WORD_BITS;

	logic                 f_valid;
	logic [ITEM_BITS-1:0] f_data;
	logic                 q_full;
	logic                 q_empty;
	logic [ITEM_BITS-1:0] q_data;
	logic                 b_take;

	// front: registers each transfer and tags it with its class
	cau_front #(
		.WORD_BITS(WORD_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.cmd        (cmd),
		.a_re       (a_re),
		.a_im       (a_im),
		.b_re       (b_re),
		.b_im       (b_im),
		.item_valid (f_valid),
		.item_data  (f_data),
		.q_full     (q_full)
	);

	// short queue so front and back stall independently
	cau_queue #(
		.DATA_BITS(ITEM_BITS)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (f_valid),
		.wr_data (f_data),
		.q_full  (q_full),
		.rd_en   (b_take),
		.q_empty (q_empty),
		.rd_data (q_data)
	);

	// back: arithmetic pipeline ending in the result register
	cau_back #(
		.WORD_BITS(WORD_BITS),
		.FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (!q_empty),
		.in_data      (q_data),
		.in_take      (b_take),
		.empty        (empty),
		.pop          (pop),
		.res_re       (res_re),
		.res_im       (res_im),
		.zero_divisor (zero_divisor),
		.overflowed   (overflowed)
	);

endmodule

// ===== rtl/core/cau_front.sv =====
// front stage: takes input transfers and classifies each item
module cau_front #(
	parameter int WORD_BITS = 32
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        push,
	output logic                                        full,
	input  logic [cau_pkg::CMD_BITS-1:0]                cmd,
	input  logic signed [WORD_BITS-1:0]                 a_re,
	input  logic signed [WORD_BITS-1:0]                 a_im,
	input  logic signed [WORD_BITS-1:0]                 b_re,
	input  logic signed [WORD_BITS-1:0]                 b_im,
	output logic                                        item_valid,
	output logic [cau_pkg::CLS_BITS+4*WORD_BITS-1:0]    item_data,
	input  logic                                        q_full
);

	cau_pkg::cls_t cls;
	logic          accept;
	logic          v_s1;
	logic [cau_pkg::CLS_BITS+4*WORD_BITS-1:0] data_s1;

	always_comb begin
		unique case (cmd)
			cau_pkg::CMD_ADD:  cls = cau_pkg::CLS_ADD;
			cau_pkg::CMD_SUB:  cls = cau_pkg::CLS_SUB;
			cau_pkg::CMD_MUL:  cls = cau_pkg::CLS_MUL;
			cau_pkg::CMD_DIV:  cls = (b_re == '0 && b_im == '0) ? cau_pkg::CLS_ZDIV
			                                                    : cau_pkg::CLS_DIV;
			cau_pkg::CMD_NEG:  cls = cau_pkg::CLS_NEG;
			cau_pkg::CMD_ADDR: cls = cau_pkg::CLS_ADDR;
			cau_pkg::CMD_SUBR: cls = cau_pkg::CLS_SUBR;
			cau_pkg::CMD_MULR: cls = cau_pkg::CLS_MULR;
			cau_pkg::CMD_DIVR: cls = (b_re == '0) ? cau_pkg::CLS_ZDIV : cau_pkg::CLS_DIVR;
			default:           cls = cau_pkg::CLS_NONE;
		endcase
	end

	assign full   = v_s1 && q_full;
	assign accept = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!v_s1 || !q_full) begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1 <= {cls, a_re, a_im, b_re, b_im};
		end
	end

	assign item_valid = v_s1;
	assign item_data  = data_s1;

endmodule

// ===== rtl/core/cau_queue.sv =====
// two-entry queue between front and back
module cau_queue #(
	parameter int DATA_BITS = 132
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [DATA_BITS-1:0] wr_data,
	output logic                 q_full,
	input  logic                 rd_en,
	output logic                 q_empty,
	output logic [DATA_BITS-1:0] rd_data
);

	logic [DATA_BITS-1:0] mem_q [0:1];
	logic                 wr_ptr_q;
	logic                 rd_ptr_q;
	logic [1:0]           count_q;
	logic                 do_wr;
	logic                 do_rd;

	assign q_full  = (count_q == 2'd2);
	assign q_empty = (count_q == 2'd0);
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && !q_empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_wr) wr_ptr_q <= !wr_ptr_q;
			if (do_rd) rd_ptr_q <= !rd_ptr_q;
			if (do_wr && !do_rd) count_q <= count_q + 2'd1;
			else if (do_rd && !do_wr) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wr_ptr_q] <= wr_data;
	end

endmodule

// ===== rtl/core/cau_back.sv =====
// back pipeline: products, rounding, pipelined divider, saturation
module cau_back #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	input  logic [cau_pkg::CLS_BITS+4*WORD_BITS-1:0] in_data,
	output logic                                     in_take,
	output logic                                     empty,
	input  logic                                     pop,
	output logic signed [WORD_BITS-1:0]              res_re,
	output logic signed [WORD_BITS-1:0]              res_im,
	output logic                                     zero_divisor,
	output logic                                     overflowed
);

	localparam int W   = WORD_BITS;
	localparam int PW  = 2 * W;
	localparam int VW  = 2 * W + 2;
	localparam int RW  = 2 * W + 1;
	localparam int NW  = 2 * W + FRAC_BITS + 2;
	localparam int TW  = W + FRAC_BITS + 1;
	localparam int QW  = W + 1;
	localparam int NST = W + 1;

	localparam logic signed [VW-1:0] SMAX = {{(VW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [VW-1:0] SMIN = {{(VW-W+1){1'b1}}, {(W-1){1'b0}}};

	typedef struct packed {
		cau_pkg::cls_t      cls;
		logic signed [PW-1:0] p0, p1, p2, p3, p4, p5;
		logic signed [W:0]    lin_re, lin_im;
		logic signed [W-1:0]  sc;
	} b1_t;

	typedef struct packed {
		cau_pkg::cls_t        cls;
		logic signed [VW-1:0] x_re, x_im;
		logic [PW-1:0]        den;
		logic                 negd;
	} b2_t;

	typedef struct packed {
		cau_pkg::cls_t        cls;
		logic signed [VW-1:0] x_re, x_im;
		logic [RW-1:0]        rem_re, rem_im;
		logic [QW-1:0]        low_re, low_im;
		logic [QW-1:0]        q_re, q_im;
		logic                 ovf_re, ovf_im;
		logic                 neg_re, neg_im;
		logic [RW-1:0]        d2;
	} ds_t;

	function automatic logic signed [VW-1:0] rnd(input logic signed [VW-1:0] x);
		logic [VW-1:0] m;
		m = x[VW-1] ? (~x + 1'b1) : x;
		m = m + ({{(VW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1));
		m = m >> FRAC_BITS;
		return x[VW-1] ? -$signed(m) : $signed(m);
	endfunction

	function automatic ds_t dstep(input ds_t d);
		ds_t           o;
		logic [RW:0]   r2;
		logic          qb;
		o  = d;
		r2 = {d.rem_re, d.low_re[QW-1]};
		qb = (r2 >= {1'b0, d.d2});
		if (qb) r2 = r2 - {1'b0, d.d2};
		o.rem_re = r2[RW-1:0];
		o.low_re = {d.low_re[QW-2:0], 1'b0};
		o.q_re   = {d.q_re[QW-2:0], qb};
		r2 = {d.rem_im, d.low_im[QW-1]};
		qb = (r2 >= {1'b0, d.d2});
		if (qb) r2 = r2 - {1'b0, d.d2};
		o.rem_im = r2[RW-1:0];
		o.low_im = {d.low_im[QW-2:0], 1'b0};
		o.q_im   = {d.q_im[QW-2:0], qb};
		return o;
	endfunction

	logic en;
	logic v_s1, v_s2;
	b1_t  b1_s1;
	b2_t  b2_s2;
	b1_t  b1_d;
	b2_t  b2_d;
	ds_t  ds_d;
	logic v_s3 [0:NST];
	ds_t  ds_s3 [0:NST];
	logic v_out_q;

	logic signed [W-1:0] ar, ai, br, bi;
	cau_pkg::cls_t       in_cls;

	assign en      = !v_out_q || pop;
	assign in_take = en && in_valid;
	assign empty   = !v_out_q;

	assign in_cls = cau_pkg::cls_t'(in_data[cau_pkg::CLS_BITS+4*W-1:4*W]);
	assign ar = in_data[4*W-1:3*W];
	assign ai = in_data[3*W-1:2*W];
	assign br = in_data[2*W-1:W];
	assign bi = in_data[W-1:0];

	// products and linear ops
	always_comb begin
		b1_d.cls = in_cls;
		b1_d.p0  = ar * br;
		b1_d.p1  = ai * bi;
		b1_d.p2  = ar * bi;
		b1_d.p3  = ai * br;
		b1_d.p4  = br * br;
		b1_d.p5  = bi * bi;
		b1_d.sc  = br;
		b1_d.lin_re = {ar[W-1], ar};
		b1_d.lin_im = {ai[W-1], ai};
		unique case (in_cls)
			cau_pkg::CLS_ADD: begin
				b1_d.lin_re = {ar[W-1], ar} + {br[W-1], br};
				b1_d.lin_im = {ai[W-1], ai} + {bi[W-1], bi};
			end
			cau_pkg::CLS_SUB: begin
				b1_d.lin_re = {ar[W-1], ar} - {br[W-1], br};
				b1_d.lin_im = {ai[W-1], ai} - {bi[W-1], bi};
			end
			cau_pkg::CLS_NEG: begin
				b1_d.lin_re = -{ar[W-1], ar};
				b1_d.lin_im = -{ai[W-1], ai};
			end
			cau_pkg::CLS_ADDR: b1_d.lin_re = {ar[W-1], ar} + {br[W-1], br};
			cau_pkg::CLS_SUBR: b1_d.lin_re = {ar[W-1], ar} - {br[W-1], br};
			default: ;
		endcase
	end

	// sums of products, rounding, divider operands
	always_comb begin
		logic [W-1:0] sabs;
		sabs = b1_s1.sc[W-1] ? (~b1_s1.sc + 1'b1) : b1_s1.sc;
		b2_d.cls  = b1_s1.cls;
		b2_d.x_re = '0;
		b2_d.x_im = '0;
		b2_d.den  = '0;
		b2_d.negd = 1'b0;
		unique case (b1_s1.cls)
			cau_pkg::CLS_ADD, cau_pkg::CLS_SUB, cau_pkg::CLS_NEG,
			cau_pkg::CLS_ADDR, cau_pkg::CLS_SUBR: begin
				b2_d.x_re = VW'(b1_s1.lin_re);
				b2_d.x_im = VW'(b1_s1.lin_im);
			end
			cau_pkg::CLS_MUL: begin
				b2_d.x_re = rnd(VW'(b1_s1.p0) - VW'(b1_s1.p1));
				b2_d.x_im = rnd(VW'(b1_s1.p2) + VW'(b1_s1.p3));
			end
			cau_pkg::CLS_MULR: begin
				b2_d.x_re = rnd(VW'(b1_s1.p0));
				b2_d.x_im = rnd(VW'(b1_s1.p3));
			end
			cau_pkg::CLS_DIV: begin
				b2_d.x_re = VW'(b1_s1.p0) + VW'(b1_s1.p1);
				b2_d.x_im = VW'(b1_s1.p3) - VW'(b1_s1.p2);
				b2_d.den  = PW'($unsigned(b1_s1.p4)) + PW'($unsigned(b1_s1.p5));
			end
			cau_pkg::CLS_DIVR: begin
				b2_d.x_re = VW'(b1_s1.lin_re);
				b2_d.x_im = VW'(b1_s1.lin_im);
				b2_d.den  = {{W{1'b0}}, sabs};
				b2_d.negd = b1_s1.sc[W-1];
			end
			default: ;
		endcase
	end

	// divider setup: scaled dividend, range check, initial remainder
	always_comb begin
		logic [VW-1:0] mre, mim;
		logic [NW-1:0] nre, nim;
		logic [RW-1:0] tre, tim;
		mre = b2_s2.x_re[VW-1] ? (~b2_s2.x_re + 1'b1) : b2_s2.x_re;
		mim = b2_s2.x_im[VW-1] ? (~b2_s2.x_im + 1'b1) : b2_s2.x_im;
		nre = ({{(NW-PW){1'b0}}, mre[PW-1:0]} << (FRAC_BITS + 1))
		      + {{(NW-PW){1'b0}}, b2_s2.den};
		nim = ({{(NW-PW){1'b0}}, mim[PW-1:0]} << (FRAC_BITS + 1))
		      + {{(NW-PW){1'b0}}, b2_s2.den};
		tre = {{(RW-TW){1'b0}}, nre[NW-1:QW]};
		tim = {{(RW-TW){1'b0}}, nim[NW-1:QW]};
		ds_d.cls    = b2_s2.cls;
		ds_d.x_re   = b2_s2.x_re;
		ds_d.x_im   = b2_s2.x_im;
		ds_d.d2     = {b2_s2.den, 1'b0};
		ds_d.rem_re = tre;
		ds_d.rem_im = tim;
		ds_d.low_re = nre[QW-1:0];
		ds_d.low_im = nim[QW-1:0];
		ds_d.q_re   = '0;
		ds_d.q_im   = '0;
		ds_d.ovf_re = (tre >= {b2_s2.den, 1'b0});
		ds_d.ovf_im = (tim >= {b2_s2.den, 1'b0});
		ds_d.neg_re = b2_s2.x_re[VW-1] ^ b2_s2.negd;
		ds_d.neg_im = b2_s2.x_im[VW-1] ^ b2_s2.negd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			b1_s1 <= b1_d;
			b2_s2 <= b2_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3[0] <= 1'b0;
		end else if (en) begin
			v_s3[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) ds_s3[0] <= ds_d;
	end

	for (genvar k = 0; k < NST; k++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s3[k+1] <= 1'b0;
			end else if (en) begin
				v_s3[k+1] <= v_s3[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) ds_s3[k+1] <= dstep(ds_s3[k]);
		end
	end

	// sign, saturation and flags
	logic signed [W-1:0] fin_re, fin_im;
	logic                fin_zd, fin_ov;

	always_comb begin
		ds_t                  f;
		logic signed [VW-1:0] vre, vim;
		logic                 is_div;
		logic                 ore, oim;
		f      = ds_s3[NST];
		is_div = (f.cls == cau_pkg::CLS_DIV) || (f.cls == cau_pkg::CLS_DIVR);
		vre    = f.x_re;
		vim    = f.x_im;
		ore    = 1'b0;
		oim    = 1'b0;
		if (is_div) begin
			vre = f.neg_re ? -$signed({{(VW-QW){1'b0}}, f.q_re})
			               : $signed({{(VW-QW){1'b0}}, f.q_re});
			vim = f.neg_im ? -$signed({{(VW-QW){1'b0}}, f.q_im})
			               : $signed({{(VW-QW){1'b0}}, f.q_im});
			if (f.ovf_re) vre = f.neg_re ? SMIN - 1 : SMAX + 1;
			if (f.ovf_im) vim = f.neg_im ? SMIN - 1 : SMAX + 1;
		end
		if (vre > SMAX) begin
			fin_re = SMAX[W-1:0];
			ore    = 1'b1;
		end else if (vre < SMIN) begin
			fin_re = SMIN[W-1:0];
			ore    = 1'b1;
		end else begin
			fin_re = vre[W-1:0];
		end
		if (vim > SMAX) begin
			fin_im = SMAX[W-1:0];
			oim    = 1'b1;
		end else if (vim < SMIN) begin
			fin_im = SMIN[W-1:0];
			oim    = 1'b1;
		end else begin
			fin_im = vim[W-1:0];
		end
		fin_zd = (f.cls == cau_pkg::CLS_ZDIV);
		fin_ov = ore || oim;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out_q <= 1'b0;
		end else if (en) begin
			v_out_q <= v_s3[NST];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_re       <= fin_re;
			res_im       <= fin_im;
			zero_divisor <= fin_zd;
			overflowed   <= fin_ov;
		end
	end

endmodule
